### rtl/rcpfm_pkg.sv
// ----------------------------------------------------------------------------
// rcpfm_pkg
// shared types, register indexes and reset values of the rc failsafe mux
// ----------------------------------------------------------------------------
package rcpfm_pkg;

  // default sizes of the per-channel history and time accumulators
  localparam int HistoryBitsDef = 8;
  localparam int TimeBitsDef    = 20;

  // configuration register widths
  localparam int CfgStepW  = 16;
  localparam int CfgTimeW  = 20;
  localparam int CfgCountW = 4;
  localparam int CfgDataW  = 20;
  localparam int CfgIdxW   = 3;

  // stream payload widths
  localparam int InDataW  = 8;
  localparam int OutDataW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTickStep       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSignalTimeout  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinPeriod      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxPeriod      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinOn          = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxOn          = 3'd5;
  localparam logic [CfgIdxW-1:0] RegValidNeeded    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegManualThresh   = 3'd7;

  // register reset values
  localparam logic [CfgStepW-1:0]  RstTickStep      = 16'd100;
  localparam logic [CfgTimeW-1:0]  RstSignalTimeout = 20'd60000;
  localparam logic [CfgTimeW-1:0]  RstMinPeriod     = 20'd5000;
  localparam logic [CfgTimeW-1:0]  RstMaxPeriod     = 20'd50000;
  localparam logic [CfgTimeW-1:0]  RstMinOn         = 20'd300;
  localparam logic [CfgTimeW-1:0]  RstMaxOn         = 20'd3000;
  localparam logic [CfgCountW-1:0] RstValidNeeded   = 4'd3;
  localparam logic [CfgTimeW-1:0]  RstManualThresh  = 20'd1500;

  // mux selection codes
  typedef enum logic [1:0] {
    SEL_NONE   = 2'd0,
    SEL_MANUAL = 2'd1,
    SEL_AUTO   = 2'd2
  } sel_t;

  typedef struct packed {
    logic [CfgStepW-1:0]  tick_step;
    logic [CfgTimeW-1:0]  signal_timeout;
    logic [CfgTimeW-1:0]  min_period;
    logic [CfgTimeW-1:0]  max_period;
    logic [CfgTimeW-1:0]  min_on;
    logic [CfgTimeW-1:0]  max_on;
    logic [CfgCountW-1:0] valid_needed;
    logic [CfgTimeW-1:0]  manual_threshold;
  } cfg_t;

  // per-channel status toward the selection logic
  typedef struct packed {
    logic rise;        // rising edge closed a pulse this tick
    logic dec;         // countdown stepped down this tick
    logic active_cur;  // countdown at zero before this tick
    logic active_nxt;  // countdown at zero after this tick
    logic above_thr;   // on time above manual threshold
  } chan_evt_t;

endpackage

### rtl/rcpfm_cfg.sv
// ----------------------------------------------------------------------------
// rcpfm_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module rcpfm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rcpfm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rcpfm_pkg::CfgDataW-1:0] cfg_wdata,
  output rcpfm_pkg::cfg_t                cfg
);

  rcpfm_pkg::cfg_t cfg_r;
  rcpfm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rcpfm_pkg::RegTickStep:
          cfg_nxt.tick_step = cfg_wdata[rcpfm_pkg::CfgStepW-1:0];
        rcpfm_pkg::RegSignalTimeout:
          cfg_nxt.signal_timeout = cfg_wdata[rcpfm_pkg::CfgTimeW-1:0];
        rcpfm_pkg::RegMinPeriod:
          cfg_nxt.min_period = cfg_wdata[rcpfm_pkg::CfgTimeW-1:0];
        rcpfm_pkg::RegMaxPeriod:
          cfg_nxt.max_period = cfg_wdata[rcpfm_pkg::CfgTimeW-1:0];
        rcpfm_pkg::RegMinOn:
          cfg_nxt.min_on = cfg_wdata[rcpfm_pkg::CfgTimeW-1:0];
        rcpfm_pkg::RegMaxOn:
          cfg_nxt.max_on = cfg_wdata[rcpfm_pkg::CfgTimeW-1:0];
        rcpfm_pkg::RegValidNeeded:
          cfg_nxt.valid_needed = cfg_wdata[rcpfm_pkg::CfgCountW-1:0];
        rcpfm_pkg::RegManualThresh:
          cfg_nxt.manual_threshold = cfg_wdata[rcpfm_pkg::CfgTimeW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_step        <= rcpfm_pkg::RstTickStep;
      cfg_r.signal_timeout   <= rcpfm_pkg::RstSignalTimeout;
      cfg_r.min_period       <= rcpfm_pkg::RstMinPeriod;
      cfg_r.max_period       <= rcpfm_pkg::RstMaxPeriod;
      cfg_r.min_on           <= rcpfm_pkg::RstMinOn;
      cfg_r.max_on           <= rcpfm_pkg::RstMaxOn;
      cfg_r.valid_needed     <= rcpfm_pkg::RstValidNeeded;
      cfg_r.manual_threshold <= rcpfm_pkg::RstManualThresh;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/rcpfm_chan.sv
// ----------------------------------------------------------------------------
// rcpfm_chan
// one receiver channel: pin history, on/off time, pulse check, countdown
// ----------------------------------------------------------------------------
module rcpfm_chan #(
  parameter int HISTORY_BITS = rcpfm_pkg::HistoryBitsDef,
  parameter int TIME_BITS    = rcpfm_pkg::TimeBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 level,
  input  logic                 clr_low_on_rise,
  input  rcpfm_pkg::cfg_t      cfg,
  output rcpfm_pkg::chan_evt_t evt
);

  // compare width covers the period sum and the 20-bit register values
  localparam int CmpW = (TIME_BITS >= rcpfm_pkg::CfgTimeW) ?
                        TIME_BITS + 1 : rcpfm_pkg::CfgTimeW + 1;

  logic [HISTORY_BITS-1:0]         hist_r, hist_nxt, hist_new;
  logic [TIME_BITS-1:0]            high_r, high_nxt, high_new;
  logic [TIME_BITS-1:0]            low_r, low_nxt, low_new;
  logic [rcpfm_pkg::CfgCountW-1:0] pend_r, pend_nxt, pend_ld;
  logic [TIME_BITS:0]              acc_in, acc_sum;
  logic [TIME_BITS-1:0]            acc_sat;
  logic [CmpW-1:0]                 period, high_c;
  logic                            rise, fall, pulse_ok, timed_out, dec;

  // one shared saturating adder: only the pin's active accumulator moves
  assign acc_in  = {1'b0, (level ? high_r : low_r)};
  assign acc_sum = acc_in + (TIME_BITS+1)'(cfg.tick_step);
  assign acc_sat = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];

  assign high_new = level ? acc_sat : high_r;
  assign low_new  = level ? low_r : acc_sat;
  assign hist_new = {hist_r[HISTORY_BITS-2:0], level};

  assign rise = (hist_new == HISTORY_BITS'(1));
  assign fall = (hist_new == ~HISTORY_BITS'(1));

  assign timed_out = !level &&
                     (CmpW'(low_new) > CmpW'(cfg.signal_timeout));
  assign pend_ld   = timed_out ? cfg.valid_needed : pend_r;

  assign period   = CmpW'(high_new) + CmpW'(low_new);
  assign high_c   = CmpW'(high_new);
  assign pulse_ok = (period > CmpW'(cfg.min_period)) &&
                    (period < CmpW'(cfg.max_period)) &&
                    (high_c > CmpW'(cfg.min_on)) &&
                    (high_c < CmpW'(cfg.max_on));

  assign dec      = rise && (pend_ld != '0) && pulse_ok;
  assign pend_nxt = dec ? pend_ld - rcpfm_pkg::CfgCountW'(1) : pend_ld;

  assign hist_nxt = hist_new;
  assign high_nxt = rise ? '0 : high_new;
  assign low_nxt  = (fall || (rise && clr_low_on_rise)) ? '0 : low_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      high_r <= '0;
      low_r  <= '0;
      pend_r <= rcpfm_pkg::RstValidNeeded;
    end else if (adv) begin
      hist_r <= hist_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign evt.rise       = rise;
  assign evt.dec        = dec;
  assign evt.active_cur = (pend_r == '0);
  assign evt.active_nxt = (pend_nxt == '0);
  assign evt.above_thr  = (high_c > CmpW'(cfg.manual_threshold));

endmodule

### rtl/rcpfm_sel.sv
// ----------------------------------------------------------------------------
// rcpfm_sel
// held mux selection between manual rc and autonomous control
// ----------------------------------------------------------------------------
module rcpfm_sel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  rcpfm_pkg::chan_evt_t evt_a,
  input  rcpfm_pkg::chan_evt_t evt_b,
  output rcpfm_pkg::sel_t      sel_nxt
);

  rcpfm_pkg::sel_t sel_r;

  // later rules override earlier ones, in channel order
  always_comb begin
    sel_nxt = sel_r;
    if (evt_a.rise && evt_a.dec && evt_a.active_nxt && !evt_b.active_cur) begin
      sel_nxt = rcpfm_pkg::SEL_MANUAL;
    end
    if (evt_b.rise && evt_b.active_nxt) begin
      sel_nxt = evt_b.above_thr ? rcpfm_pkg::SEL_MANUAL : rcpfm_pkg::SEL_AUTO;
    end
    if (!evt_a.active_nxt && !evt_b.active_nxt) begin
      sel_nxt = rcpfm_pkg::SEL_AUTO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= rcpfm_pkg::SEL_NONE;
    end else if (adv) begin
      sel_r <= sel_nxt;
    end
  end

endmodule

### rtl/rc_pulse_failsafe_mux_unit.sv
// ----------------------------------------------------------------------------
// rc_pulse_failsafe_mux_unit
// path: an accepted request waits in the input stage, then goes to the result
//   register; throughput: 1 request per cycle unless out_tready stalls it;
//   state update is one pass through the per-channel add and window compares
// reset: synchronous active low; clears the pipeline, loads register defaults
// ----------------------------------------------------------------------------
module rc_pulse_failsafe_mux_unit #(
  parameter int HISTORY_BITS = rcpfm_pkg::HistoryBitsDef,
  parameter int TIME_BITS    = rcpfm_pkg::TimeBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rcpfm_pkg::InDataW-1:0]  in_tdata,   // [0] ch1_level, [1] ch3_level
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rcpfm_pkg::OutDataW-1:0] out_tdata,  // [1:0] mux_select,
                                                     // [2] ch1_active, [3] ch3_active
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [rcpfm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rcpfm_pkg::CfgDataW-1:0] cfg_wdata
);

  rcpfm_pkg::cfg_t      cfg;
  rcpfm_pkg::chan_evt_t evt_a, evt_b;
  rcpfm_pkg::sel_t      sel_nxt;

  // input stage: holds one sampled tick
  logic       in_vld_r;
  logic       lvl_a_r, lvl_b_r;
  // result stage
  logic                           out_vld_r;
  logic [rcpfm_pkg::OutDataW-1:0] out_data_r;
  logic                           adv;

  // a tick moves from the input stage into the result register (and the
  // channel state updates) whenever the result register is free or drains
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  // input stage takes a new request when empty or when it advances
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      lvl_a_r <= in_tdata[0];
      lvl_b_r <= in_tdata[1];
    end
  end

  rcpfm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // channel 1: rising edge clears only the on time
  rcpfm_chan #(
    .HISTORY_BITS (HISTORY_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_chan_a (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .level           (lvl_a_r),
    .clr_low_on_rise (1'b0),
    .cfg             (cfg),
    .evt             (evt_a)
  );

  // channel 3: rising edge clears both on and off time
  rcpfm_chan #(
    .HISTORY_BITS (HISTORY_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_chan_b (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .level           (lvl_b_r),
    .clr_low_on_rise (1'b1),
    .cfg             (cfg),
    .evt             (evt_b)
  );

  rcpfm_sel u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .evt_a   (evt_a),
    .evt_b   (evt_b),
    .sel_nxt (sel_nxt)
  );

  // result register: state after this tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {4'b0000, evt_b.active_nxt, evt_a.active_nxt, sel_nxt};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
